[hdl/wlc_pkg.sv]
`timescale 1ns / 1ps

package wlc_pkg;

  localparam int CoordW        = 20;
  localparam int DeltaW        = CoordW + 1;
  localparam int WFrac         = 16;
  localparam int WeightW       = WFrac + 1;
  localparam int QuoW          = WFrac + 2;
  localparam int StepsPerStage = 2;
  localparam int DivStages     = QuoW / StepsPerStage;
  localparam int NumEdges      = 4;
  localparam int ProdW         = DeltaW + QuoW;

  localparam logic [QuoW-1:0]    TSat   = QuoW'((1 << WFrac) + 1);
  localparam logic [WeightW-1:0] WOne   = WeightW'(1 << WFrac);
  localparam logic [WeightW-1:0] WZero  = '0;

  typedef enum logic [1:0] {
    REG_MIN_X = 2'd0,
    REG_MIN_Y = 2'd1,
    REG_MAX_X = 2'd2,
    REG_MAX_Y = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
  } line_in_t;

  typedef struct packed {
    logic                     visible;
    logic [WeightW-1:0]       start_weight;
    logic [WeightW-1:0]       end_weight;
    logic signed [CoordW-1:0] clipped_start_x;
    logic signed [CoordW-1:0] clipped_start_y;
    logic signed [CoordW-1:0] clipped_end_x;
    logic signed [CoordW-1:0] clipped_end_y;
  } line_out_t;

endpackage

[hdl/weighted_line_clipper_top.sv]
`timescale 1ns / 1ps

// Liang-Barsky line clipper against a window held in four registers. Fully
// pipelined: one segment may enter every cycle while the output is not
// stalled. Each result passes through stage A, stage B, the divider stages,
// D, E and F. The four parallel edge ratio dividers resolve two quotient
// bits per stage over nine stages. An output stall holds the whole pipeline.
module weighted_line_clipper_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [19:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wlc_pkg::line_in_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wlc_pkg::line_out_t  out_data_o
);
  import wlc_pkg::*;

  typedef struct packed {
    logic signed [CoordW-1:0] sx;
    logic signed [CoordW-1:0] sy;
    logic signed [DeltaW-1:0] dx;
    logic signed [DeltaW-1:0] dy;
  } geo_t;

  typedef struct packed {
    logic [DeltaW-1:0] rem;
    logic [QuoW-1:0]   num;
    logic [QuoW-1:0]   quo;
    logic [DeltaW-1:0] den;
    logic              ov;
    logic              pzero;
    logic              pneg;
    logic              qneg;
  } div_t;

  function automatic div_t div_step(input div_t d);
    div_t            r;
    logic [DeltaW:0] rn;
    r  = d;
    rn = {d.rem, d.num[QuoW-1]};
    if (rn >= {1'b0, d.den}) begin
      r.rem = DeltaW'(rn - {1'b0, d.den});
      r.quo = {d.quo[QuoW-2:0], 1'b1};
    end else begin
      r.rem = rn[DeltaW-1:0];
      r.quo = {d.quo[QuoW-2:0], 1'b0};
    end
    r.num = {d.num[QuoW-2:0], 1'b0};
    return r;
  endfunction

  logic signed [CoordW-1:0] min_x_q, min_y_q, max_x_q, max_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= '0;
      min_y_q <= '0;
      max_x_q <= 20'sd524287;
      max_y_q <= 20'sd524287;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_MIN_X: min_x_q <= cfg_wdata_i;
        REG_MIN_Y: min_y_q <= cfg_wdata_i;
        REG_MAX_X: max_x_q <= cfg_wdata_i;
        REG_MAX_Y: max_y_q <= cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  logic adv;
  logic out_vld_q;
  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // stage A: deltas and edge distances
  logic                     a_vld_q;
  geo_t                     a_geo_q;
  logic signed [DeltaW-1:0] a_p_q [NumEdges];
  logic signed [DeltaW-1:0] a_q_q [NumEdges];
  geo_t                     a_geo_d;
  logic signed [DeltaW-1:0] a_p_d [NumEdges];
  logic signed [DeltaW-1:0] a_q_d [NumEdges];

  always_comb begin
    a_geo_d.sx = in_data_i.start_x;
    a_geo_d.sy = in_data_i.start_y;
    a_geo_d.dx = DeltaW'(in_data_i.end_x) - DeltaW'(in_data_i.start_x);
    a_geo_d.dy = DeltaW'(in_data_i.end_y) - DeltaW'(in_data_i.start_y);
    a_p_d[0]   = -a_geo_d.dx;
    a_p_d[1]   = a_geo_d.dx;
    a_p_d[2]   = -a_geo_d.dy;
    a_p_d[3]   = a_geo_d.dy;
    a_q_d[0]   = DeltaW'(in_data_i.start_x) - DeltaW'(min_x_q);
    a_q_d[1]   = DeltaW'(max_x_q) - DeltaW'(in_data_i.start_x);
    a_q_d[2]   = DeltaW'(in_data_i.start_y) - DeltaW'(min_y_q);
    a_q_d[3]   = DeltaW'(max_y_q) - DeltaW'(in_data_i.start_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else if (adv) a_vld_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_geo_q <= a_geo_d;
      a_p_q   <= a_p_d;
      a_q_q   <= a_q_d;
    end
  end

  // stage B and divider stages
  logic [DivStages:0] dv_vld_q;
  geo_t               dv_geo_q [DivStages+1];
  div_t               dv_q     [DivStages+1][NumEdges];
  div_t               init_d   [NumEdges];

  always_comb begin
    for (int e = 0; e < NumEdges; e++) begin
      logic [DeltaW-2:0] nq, dp;
      logic [DeltaW+QuoW-2:0] n;
      nq = a_q_q[e][DeltaW-1] ? (DeltaW-1)'(-a_q_q[e]) : a_q_q[e][DeltaW-2:0];
      dp = a_p_q[e][DeltaW-1] ? (DeltaW-1)'(-a_p_q[e]) : a_p_q[e][DeltaW-2:0];
      n  = {nq, (QuoW-1)'(0)} + (DeltaW+QuoW-1)'(dp);
      init_d[e].rem   = {1'b0, n[DeltaW+QuoW-2:QuoW]};
      init_d[e].num   = n[QuoW-1:0];
      init_d[e].quo   = '0;
      init_d[e].den   = {dp, 1'b0};
      init_d[e].ov    = {1'b0, n[DeltaW+QuoW-2:QuoW]} >= {dp, 1'b0};
      init_d[e].pzero = (a_p_q[e] == '0);
      init_d[e].pneg  = a_p_q[e][DeltaW-1];
      init_d[e].qneg  = a_q_q[e][DeltaW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_vld_q <= '0;
    else if (adv) dv_vld_q <= {dv_vld_q[DivStages-1:0], a_vld_q};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_geo_q[0] <= a_geo_q;
      dv_q[0]     <= init_d;
    end
  end

  for (genvar s = 1; s <= DivStages; s++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_geo_q[s] <= dv_geo_q[s-1];
        for (int e = 0; e < NumEdges; e++) begin
          dv_q[s][e] <= div_step(div_step(dv_q[s-1][e]));
        end
      end
    end
  end

  // stage D: edge tests in order left, right, top, bottom
  logic               d_vld_q, d_ok_q, d_ok_d;
  geo_t               d_geo_q;
  logic [WeightW-1:0] d_w0_q, d_w1_q, d_w0_d, d_w1_d;

  always_comb begin
    logic signed [QuoW:0] t, w0, w1;
    logic [QuoW-1:0]      r;
    div_t                 dd;
    w0     = '0;
    w1     = (QuoW+1)'(WOne);
    d_ok_d = 1'b1;
    for (int e = 0; e < NumEdges; e++) begin
      dd = dv_q[DivStages][e];
      r  = (dd.ov || dd.quo > TSat) ? TSat : dd.quo;
      t  = (dd.pneg ^ dd.qneg) ? -$signed({1'b0, r}) : $signed({1'b0, r});
      if (dd.pzero) begin
        if (dd.qneg) d_ok_d = 1'b0;
      end else if (dd.pneg) begin
        if (t > w1) d_ok_d = 1'b0;
        else if (t > w0) w0 = t;
      end else begin
        if (t < w0) d_ok_d = 1'b0;
        else if (t < w1) w1 = t;
      end
    end
    if (w1 < w0) d_ok_d = 1'b0;
    d_w0_d = w0[WeightW-1:0];
    d_w1_d = w1[WeightW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_vld_q <= 1'b0;
    else if (adv) d_vld_q <= dv_vld_q[DivStages];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_geo_q <= dv_geo_q[DivStages];
      d_ok_q  <= d_ok_d;
      d_w0_q  <= d_w0_d;
      d_w1_q  <= d_w1_d;
    end
  end

  // stage E: delta times weight
  logic                     e_vld_q, e_ok_q;
  logic signed [CoordW-1:0] e_sx_q, e_sy_q;
  logic [WeightW-1:0]       e_w0_q, e_w1_q;
  logic signed [ProdW-1:0]  e_prod_q [NumEdges];
  logic signed [ProdW-1:0]  e_prod_d [NumEdges];
  logic signed [ProdW-1:0]  dxe, dye, w0e, w1e;

  always_comb begin
    dxe = ProdW'(d_geo_q.dx);
    dye = ProdW'(d_geo_q.dy);
    w0e = $signed({(ProdW-WeightW)'(0), d_w0_q});
    w1e = $signed({(ProdW-WeightW)'(0), d_w1_q});
    e_prod_d[0] = dxe * w0e;
    e_prod_d[1] = dye * w0e;
    e_prod_d[2] = dxe * w1e;
    e_prod_d[3] = dye * w1e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e_vld_q <= 1'b0;
    else if (adv) e_vld_q <= d_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_ok_q   <= d_ok_q;
      e_sx_q   <= d_geo_q.sx;
      e_sy_q   <= d_geo_q.sy;
      e_w0_q   <= d_w0_q;
      e_w1_q   <= d_w1_q;
      e_prod_q <= e_prod_d;
    end
  end

  // stage F: round, add start, zero on reject
  line_out_t               out_q, out_d;
  logic signed [ProdW-1:0] rnd [NumEdges];

  always_comb begin
    for (int e = 0; e < NumEdges; e++) begin
      rnd[e] = e_prod_q[e] + ProdW'(1 << (WFrac-1));
    end
    out_d = '0;
    if (e_ok_q) begin
      out_d.visible         = 1'b1;
      out_d.start_weight    = e_w0_q;
      out_d.end_weight      = e_w1_q;
      out_d.clipped_start_x = e_sx_q + rnd[0][WFrac+CoordW-1:WFrac];
      out_d.clipped_start_y = e_sy_q + rnd[1][WFrac+CoordW-1:WFrac];
      out_d.clipped_end_x   = e_sx_q + rnd[2][WFrac+CoordW-1:WFrac];
      out_d.clipped_end_y   = e_sy_q + rnd[3][WFrac+CoordW-1:WFrac];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (adv) out_vld_q <= e_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
